@@ sv/tcsc_pkg.sv @@
// Package for the tram crossing signal controller: mode codes, register
// indexes, lamp and ramp constants, and the structs shared by the modules.
// No dependencies.
`default_nettype none

package tcsc_pkg;

    typedef enum logic [2:0] {
        MODE_WAIT   = 3'd0,
        MODE_SEEN   = 3'd1,
        MODE_PASSED = 3'd2,
        MODE_FAULT  = 3'd3,
        MODE_TEST   = 3'd4
    } mode_t;

    typedef enum logic [2:0] {
        REG_BREATHE_STEP = 3'd0,
        REG_BLINK_STEP   = 3'd1,
        REG_ARRIVE_HOLD  = 3'd2,
        REG_STOP_HOLD    = 3'd3,
        REG_CLEAR_TIME   = 3'd4,
        REG_LED_ON       = 3'd5,
        REG_LED_OFF      = 3'd6
    } reg_index_t;

    localparam int IN_DATA_W  = 40;
    localparam int OUT_DATA_W = 24;
    localparam int CFG_DATA_W = 16;

    // Ramp bands in tenths of a PWM level
    localparam logic [11:0] WAIT_LOW_TENTHS  = 12'd1250;
    localparam logic [11:0] WAIT_HIGH_TENTHS = 12'd1800;
    localparam logic [11:0] SEEN_LOW_TENTHS  = 12'd500;
    localparam logic [11:0] SEEN_HIGH_TENTHS = 12'd2550;
    localparam logic [11:0] SEEN_ON_TENTHS   = 12'd2000;

    localparam logic [7:0] FULL_LEVEL = 8'd255;
    localparam logic [7:0] OFF_LEVEL  = 8'd0;

    // ceil(2^16 / 10): exact floor(x / 10) for x below 16384
    localparam logic [12:0] DIV10_RECIP = 13'd6554;

    localparam logic [9:0]  RST_BREATHE_STEP = 10'd6;
    localparam logic [9:0]  RST_BLINK_STEP   = 10'd100;
    localparam logic [15:0] RST_ARRIVE_HOLD  = 16'd500;
    localparam logic [15:0] RST_STOP_HOLD    = 16'd400;
    localparam logic [15:0] RST_CLEAR_TIME   = 16'd6000;
    localparam logic [15:0] RST_LED_ON       = 16'd1000;
    localparam logic [15:0] RST_LED_OFF      = 16'd500;

    typedef struct packed {
        logic [9:0]  breathe_step;
        logic [9:0]  blink_step;
        logic [15:0] arrive_hold_ms;
        logic [15:0] stop_hold_ms;
        logic [15:0] clear_time_ms;
        logic [15:0] led_on_ms;
        logic [15:0] led_off_ms;
    } cfg_t;

    typedef struct packed {
        mode_t       mode;
        logic [11:0] level_tenths;
        logic        rising;
        logic [31:0] hold_mark_ms;
        logic        indicator_state;
        logic [31:0] indicator_mark_ms;
    } state_t;

    typedef struct packed {
        logic [31:0] now_ms;
        logic        sensor_one;
        logic        sensor_two;
        logic        sensor_three;
        logic        sensor_four;
        logic        test_switch;
    } item_t;

    typedef struct packed {
        logic [7:0] red_level;
        logic [7:0] green_level;
        logic       indicator_on;
        mode_t      mode;
    } result_t;

endpackage

`default_nettype wire

@@ sv/tcsc_core.sv @@
// Per-tick logic of the crossing controller: mode selection, hold timers,
// brightness ramp, lamp levels and indicator blink. Purely combinational.
// Depends on tcsc_pkg.
`default_nettype none

module tcsc_core (
    input  var tcsc_pkg::cfg_t    cfg,
    input  var tcsc_pkg::state_t  state,
    input  var tcsc_pkg::item_t   item,
    output tcsc_pkg::state_t      state_next,
    output tcsc_pkg::result_t     result
);

    logic               s1, s2, s3, s4, test_req;
    tcsc_pkg::mode_t    run_mode;
    logic [31:0]        hold_elapsed;
    logic [31:0]        ind_elapsed;
    logic [9:0]         step;
    logic [11:0]        band_lo, band_hi;
    logic signed [13:0] ramp_sum;
    logic [11:0]        ramp_level;
    logic               ramp_rising;
    logic [24:0]        div_prod;

    always_comb
    begin
        s1       = ~item.sensor_one;
        s2       = ~item.sensor_two;
        s3       = ~item.sensor_three;
        s4       = ~item.sensor_four;
        test_req = ~item.test_switch;

        // Fault overrides test, test overrides the stored mode
        run_mode = state.mode;
        if (test_req)
            run_mode = tcsc_pkg::MODE_TEST;
        if (s1 && s2)
            run_mode = tcsc_pkg::MODE_FAULT;

        hold_elapsed = item.now_ms - state.hold_mark_ms;
        ind_elapsed  = item.now_ms - state.indicator_mark_ms;

        if (run_mode == tcsc_pkg::MODE_SEEN)
        begin
            step    = cfg.blink_step;
            band_lo = tcsc_pkg::SEEN_LOW_TENTHS;
            band_hi = tcsc_pkg::SEEN_HIGH_TENTHS;
        end
        else
        begin
            step    = cfg.breathe_step;
            band_lo = tcsc_pkg::WAIT_LOW_TENTHS;
            band_hi = tcsc_pkg::WAIT_HIGH_TENTHS;
        end

        // Step in the current direction, clamp and reverse at the band edges
        if (state.rising)
            ramp_sum = $signed({2'b00, state.level_tenths}) + $signed({4'b0000, step});
        else
            ramp_sum = $signed({2'b00, state.level_tenths}) - $signed({4'b0000, step});
        ramp_level  = ramp_sum[11:0];
        ramp_rising = state.rising;
        if (ramp_sum > $signed({2'b00, band_hi}))
        begin
            ramp_level  = band_hi;
            ramp_rising = 1'b0;
        end
        else if (ramp_sum < $signed({2'b00, band_lo}))
        begin
            ramp_level  = band_lo;
            ramp_rising = 1'b1;
        end

        div_prod = ramp_level * tcsc_pkg::DIV10_RECIP;

        state_next = state;
        state_next.mode = run_mode;
        result.red_level    = tcsc_pkg::OFF_LEVEL;
        result.green_level  = tcsc_pkg::OFF_LEVEL;
        result.indicator_on = state.indicator_state;
        result.mode         = run_mode;

        unique case (run_mode)
            tcsc_pkg::MODE_SEEN:
            begin
                if (s1)
                    state_next.hold_mark_ms = item.now_ms;
                else if (hold_elapsed > {16'd0, cfg.clear_time_ms})
                    state_next.mode = tcsc_pkg::MODE_PASSED;
                state_next.level_tenths = ramp_level;
                state_next.rising       = ramp_rising;
                if (ramp_level > tcsc_pkg::SEEN_ON_TENTHS)
                    result.red_level = tcsc_pkg::FULL_LEVEL;
            end
            tcsc_pkg::MODE_PASSED:
            begin
                result.green_level = tcsc_pkg::FULL_LEVEL;
                if (s2)
                begin
                    if (hold_elapsed > {16'd0, cfg.stop_hold_ms})
                        state_next.mode = tcsc_pkg::MODE_WAIT;
                end
                else
                    state_next.hold_mark_ms = item.now_ms;
            end
            tcsc_pkg::MODE_FAULT:
            begin
                if (!s1 && !s2)
                    state_next.mode = tcsc_pkg::MODE_WAIT;
                result.red_level   = tcsc_pkg::FULL_LEVEL;
                result.green_level = tcsc_pkg::FULL_LEVEL;
            end
            tcsc_pkg::MODE_TEST:
            begin
                if (!test_req)
                    state_next.mode = tcsc_pkg::MODE_WAIT;
                if (s3)
                    result.red_level = tcsc_pkg::FULL_LEVEL;
                if (s4)
                    result.green_level = tcsc_pkg::FULL_LEVEL;
            end
            default:
            begin
                state_next.mode = tcsc_pkg::MODE_WAIT;
                result.mode     = tcsc_pkg::MODE_WAIT;
                if (s1)
                begin
                    if (hold_elapsed > {16'd0, cfg.arrive_hold_ms})
                        state_next.mode = tcsc_pkg::MODE_SEEN;
                end
                else
                    state_next.hold_mark_ms = item.now_ms;
                state_next.level_tenths = ramp_level;
                state_next.rising       = ramp_rising;
                result.red_level   = tcsc_pkg::FULL_LEVEL;
                result.green_level = div_prod[23:16];
            end
        endcase

        // Indicator toggles after its on or off period has run out
        if (state.indicator_state)
        begin
            if (ind_elapsed > {16'd0, cfg.led_on_ms})
            begin
                state_next.indicator_mark_ms = item.now_ms;
                state_next.indicator_state   = 1'b0;
            end
        end
        else if (ind_elapsed > {16'd0, cfg.led_off_ms})
        begin
            state_next.indicator_mark_ms = item.now_ms;
            state_next.indicator_state   = 1'b1;
        end
    end

endmodule

`default_nettype wire

@@ sv/tram_crossing_signal_controller_top.sv @@
// Top level of the tram crossing signal controller: stream ports, register
// file, controller state and result register. Depends on tcsc_pkg and
// tcsc_core.
//
// Usage: each beat on the s_ channel is one control tick (timestamp, four
// active-low sensors, active-low test switch). Each tick yields exactly one
// beat on the m_ channel with the red and green lamp levels, the indicator
// LED and the mode that drove the lamps.
// The result of a tick is registered: a tick accepted at one clock edge is
// offered on m_tvalid after that edge. Throughput is one tick per cycle while
// the receiver does not stall; the controller state updates at the same edge
// the tick is accepted, so the next tick may follow immediately.
// The cfg_ port writes a register by index at any edge with cfg_we high;
// write only while no tick is in flight.
// Reset (rst_n low, asynchronous) loads the default register values, puts
// the controller in waiting mode with the indicator on and empties the
// result register.
// When the receiver stalls, the result holds and s_tready drops until the
// result is taken; a result taken in the same cycle frees the slot at once.
`default_nettype none

module tram_crossing_signal_controller_top (
    input  wire                              clk,
    input  wire                              rst_n,
    // now_ms[31:0], sensor_one[32], sensor_two[33], sensor_three[34],
    // sensor_four[35], test_switch[36], zero[39:37]
    input  wire [tcsc_pkg::IN_DATA_W-1:0]    s_tdata,
    input  wire                              s_tvalid,
    output logic                             s_tready,
    // red_level[7:0], green_level[15:8], indicator_on[16], mode[19:17],
    // zero[23:20]
    output logic [tcsc_pkg::OUT_DATA_W-1:0]  m_tdata,
    output logic                             m_tvalid,
    input  wire                              m_tready,
    input  wire                              cfg_we,
    input  wire [2:0]                        cfg_index,
    input  wire [tcsc_pkg::CFG_DATA_W-1:0]   cfg_data
);

    tcsc_pkg::cfg_t    cfg_reg;
    tcsc_pkg::state_t  state_reg, state_next;
    tcsc_pkg::item_t   item;
    tcsc_pkg::result_t result;
    tcsc_pkg::result_t result_reg;
    logic              out_valid_reg;
    logic              in_beat;

    assign s_tready = !out_valid_reg || m_tready;
    assign in_beat  = s_tvalid && s_tready;

    assign item.now_ms       = s_tdata[31:0];
    assign item.sensor_one   = s_tdata[32];
    assign item.sensor_two   = s_tdata[33];
    assign item.sensor_three = s_tdata[34];
    assign item.sensor_four  = s_tdata[35];
    assign item.test_switch  = s_tdata[36];

    tcsc_core u_core (
        .cfg        (cfg_reg),
        .state      (state_reg),
        .item       (item),
        .state_next (state_next),
        .result     (result)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.breathe_step   <= tcsc_pkg::RST_BREATHE_STEP;
            cfg_reg.blink_step     <= tcsc_pkg::RST_BLINK_STEP;
            cfg_reg.arrive_hold_ms <= tcsc_pkg::RST_ARRIVE_HOLD;
            cfg_reg.stop_hold_ms   <= tcsc_pkg::RST_STOP_HOLD;
            cfg_reg.clear_time_ms  <= tcsc_pkg::RST_CLEAR_TIME;
            cfg_reg.led_on_ms      <= tcsc_pkg::RST_LED_ON;
            cfg_reg.led_off_ms     <= tcsc_pkg::RST_LED_OFF;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                tcsc_pkg::REG_BREATHE_STEP: cfg_reg.breathe_step   <= cfg_data[9:0];
                tcsc_pkg::REG_BLINK_STEP:   cfg_reg.blink_step     <= cfg_data[9:0];
                tcsc_pkg::REG_ARRIVE_HOLD:  cfg_reg.arrive_hold_ms <= cfg_data;
                tcsc_pkg::REG_STOP_HOLD:    cfg_reg.stop_hold_ms   <= cfg_data;
                tcsc_pkg::REG_CLEAR_TIME:   cfg_reg.clear_time_ms  <= cfg_data;
                tcsc_pkg::REG_LED_ON:       cfg_reg.led_on_ms      <= cfg_data;
                tcsc_pkg::REG_LED_OFF:      cfg_reg.led_off_ms     <= cfg_data;
                default: ;
            endcase
        end
    end

    // Controller state advances on every accepted tick
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg.mode              <= tcsc_pkg::MODE_WAIT;
            state_reg.level_tenths      <= 12'd0;
            state_reg.rising            <= 1'b1;
            state_reg.hold_mark_ms      <= 32'd0;
            state_reg.indicator_state   <= 1'b1;
            state_reg.indicator_mark_ms <= 32'd0;
        end
        else if (in_beat)
            state_reg <= state_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (in_beat)
            out_valid_reg <= 1'b1;
        else if (m_tready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (in_beat)
            result_reg <= result;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {4'b0000, result_reg.mode, result_reg.indicator_on,
                       result_reg.green_level, result_reg.red_level};

endmodule

`default_nettype wire

@@ sv/tcsc_checker.sv @@
// Port-level checker for the tram crossing signal controller, bound to the
// top level. Depends on tcsc_pkg and tram_crossing_signal_controller_top.
`default_nettype none

module tcsc_checker (
    input wire                             clk,
    input wire                             rst_n,
    input wire [tcsc_pkg::IN_DATA_W-1:0]   s_tdata,
    input wire                             s_tvalid,
    input wire                             s_tready,
    input wire [tcsc_pkg::OUT_DATA_W-1:0]  m_tdata,
    input wire                             m_tvalid,
    input wire                             m_tready,
    input wire                             cfg_we,
    input wire [2:0]                       cfg_index,
    input wire [tcsc_pkg::CFG_DATA_W-1:0]  cfg_data
);

    logic [7:0] red;
    logic [7:0] green;
    logic [2:0] mode;

    assign red   = m_tdata[7:0];
    assign green = m_tdata[15:8];
    assign mode  = m_tdata[19:17];

    // Hold a stalled result
    a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result changed while stalled");

    // Waiting mode: red full, green breathing within its band
    a_wait_lamps: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && mode == tcsc_pkg::MODE_WAIT |->
            red == tcsc_pkg::FULL_LEVEL && green >= 8'd125 && green <= 8'd180)
        else $error("waiting-mode lamps out of band");

    a_fixed_lamps: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && (mode == tcsc_pkg::MODE_PASSED || mode == tcsc_pkg::MODE_FAULT) |->
            green == tcsc_pkg::FULL_LEVEL &&
            ((mode == tcsc_pkg::MODE_FAULT) == (red == tcsc_pkg::FULL_LEVEL)))
        else $error("passed or fault lamps wrong");

    // Test request without a both-sensor fault runs test mode next beat
    a_test_entry: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready && !s_tdata[36] && (s_tdata[32] || s_tdata[33]) |=>
            m_tvalid && mode == tcsc_pkg::MODE_TEST)
        else $error("test request did not select test mode");

    a_fault_entry: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready && !s_tdata[32] && !s_tdata[33] |=>
            m_tvalid && mode == tcsc_pkg::MODE_FAULT)
        else $error("both sensors did not select fault mode");

    logic unused_cfg;
    assign unused_cfg = cfg_we ^ (^cfg_index) ^ (^cfg_data);

endmodule

bind tram_crossing_signal_controller_top tcsc_checker u_tcsc_checker (.*);

`default_nettype wire
